FILE: src/dma_channel_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// DMA channel scheduler assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef DMA_CHANNEL_SCHEDULER_TOP_DEFINES_SVH
`define DMA_CHANNEL_SCHEDULER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DCS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dcs_pkg.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler package
// Shared constants, codes and request structures.
// ----------------------------------------------------------------------------
`default_nettype none
package dcs_pkg;
  localparam int NumChannels = 4;
  localparam int FifoDepth   = 8;
  localparam int ChW         = 4;
  localparam int PtrW        = 3;
  localparam int FillW       = 4;
  localparam int SlotW       = 5;
  localparam int InW         = 112;
  localparam int OutW        = 272;

  localparam logic [2:0] ActSubmit = 3'd0;
  localparam logic [2:0] ActTick   = 3'd1;
  localparam logic [2:0] ActCancel = 3'd2;
  localparam logic [2:0] ActStat   = 3'd3;
  localparam logic [2:0] ActState  = 3'd4;

  localparam logic [2:0] KindAck    = 3'd0;
  localparam logic [2:0] KindDone   = 3'd1;
  localparam logic [2:0] KindCncl   = 3'd2;
  localparam logic [2:0] KindQuiet  = 3'd3;
  localparam logic [2:0] KindCAck   = 3'd4;
  localparam logic [2:0] KindStat   = 3'd5;
  localparam logic [2:0] KindState  = 3'd6;

  localparam logic [1:0] RegRate  = 2'd0;
  localparam logic [1:0] RegLimit = 2'd1;
  localparam logic [1:0] RegChans = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] xfer_size;
    logic [31:0] xfer_count;
    logic        src_is_host;
    logic        dst_is_host;
    logic [31:0] target_id;
    logic [3:0]  stat_select;
    logic [3:0]  channel_pick;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [31:0] xfer_id;
    logic [3:0]  chan;
    logic [63:0] done_cycle;
    logic [63:0] latency;
    logic [31:0] bytes;
    logic [63:0] stat_value;
    logic [1:0]  chan_status;
    logic        last;
  } rsp_t;
endpackage
`default_nettype wire

FILE: src/dcs_req_fifo.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler request queue
// Front end: registers requests, drops unknown actions, two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dcs_req_fifo (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  dcs_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output dcs_pkg::req_t   out_req_o
);
  import dcs_pkg::*;
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop, known;

  assign known       = (in_req_i.action <= ActState);
  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o && known;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/dcs_div.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler divider
// Radix-2 restoring divider, 32-bit dividend by 11-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module dcs_div (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] num_i,
  input  wire  [10:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] q_q;
  logic [11:0] r_q;
  logic [10:0] d_q;
  logic [5:0]  n_q;
  logic        busy_q;
  logic [11:0] sh;
  logic        ge;

  // done stays up until the next start
  assign sh     = {r_q[10:0], q_q[31]};
  assign ge     = sh >= {1'b0, d_q};
  assign done_o = busy_q && (n_q == 6'd0);
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      n_q    <= 6'd32;
    end else if (busy_q && n_q != 6'd0) begin
      n_q <= n_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= 12'd0;
      d_q <= den_i;
    end else if (busy_q && n_q != 6'd0) begin
      r_q <= ge ? (sh - {1'b0, d_q}) : sh;
      q_q <= {q_q[30:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: src/dcs_engine.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler engine
// Back end: per-request sequencer over channels, slot table and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module dcs_engine (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             req_valid_i,
  output logic            req_ready_o,
  input  dcs_pkg::req_t   req_i,
  input  wire  [10:0]     rate_i,
  input  wire  [3:0]      limit_i,
  input  wire  [2:0]      chans_i,
  output logic            rsp_valid_o,
  input  wire             rsp_ready_i,
  output dcs_pkg::rsp_t   rsp_o,
  output logic            idle_o
);
  import dcs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSel  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StRet  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StBusy = 3'd6;
  localparam logic [2:0] StCan  = 3'd7;

  logic [2:0]  st_q, st_d;
  req_t        r_q;
  logic [63:0] now_q;
  logic [31:0] nid_q;
  logic [63:0] bu_q   [NumChannels];
  logic [PtrW-1:0]  hd_q [NumChannels];
  logic [FillW-1:0] fl_q [NumChannels];
  logic [31:0] eid_q  [NumChannels*FifoDepth];
  logic [31:0] esz_q  [NumChannels*FifoDepth];
  logic [63:0] esb_q  [NumChannels*FifoDepth];
  logic [63:0] edn_q  [NumChannels*FifoDepth];
  logic [2:0]  efl_q  [NumChannels*FifoDepth];
  logic [63:0] gc_q   [10];
  logic [63:0] cc_q   [NumChannels*3];
  logic [1:0]  ci_q;
  logic [ChW:0] best_q;
  logic [63:0] earl_q;
  logic [31:0] prod_q;
  logic        anyb_q;
  logic        pend_q;
  rsp_t        held_q;
  logic        ov_q;
  rsp_t        out_q;
  logic        dstart;
  logic        ddone;
  logic [31:0] dquo;
  logic [3:0]  lim;
  logic [2:0]  use_n;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] hslot;
  logic [63:0] lat;
  logic        can_emit;
  logic [63:0] dur;
  logic [63:0] start_c;
  logic [63:0] done_c;
  logic        cmatch;
  logic        due;

  dcs_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(prod_q), .den_i(rate_i),
    .done_o(ddone), .quo_o(dquo)
  );

  assign lim   = (limit_i == 4'd0 || limit_i > 4'(FifoDepth)) ? 4'(FifoDepth) : limit_i;
  assign use_n = (chans_i == 3'd0) ? 3'd1 :
                 (chans_i > 3'(NumChannels)) ? 3'(NumChannels) : chans_i;
  assign slot  = {ci_q, PtrW'(hd_q[ci_q] + fl_q[ci_q][PtrW-1:0])};
  assign hslot = {ci_q, hd_q[ci_q]};
  assign lat   = edn_q[hslot] - esb_q[hslot];
  assign due   = (fl_q[ci_q] != '0) && (edn_q[hslot] <= now_q);
  assign can_emit = !ov_q || rsp_ready_i;
  assign rsp_valid_o = ov_q;
  assign rsp_o = out_q;
  assign req_ready_o = (st_q == StIdle) && !pend_q;
  assign idle_o = (st_q == StIdle) && !pend_q && !ov_q;
  assign dstart = (st_q == StMul) && rate_i != 11'd0;
  assign dur = (rate_i == 11'd0 || dquo == 32'd0) ? 64'd1 : {32'd0, dquo};
  assign start_c = (now_q > bu_q[best_q[1:0]]) ? now_q : bu_q[best_q[1:0]];
  assign done_c = start_c + dur;
  assign cmatch = ({1'b0, ci_q} < 3'(NumChannels)) && 1'b1;

  always_comb begin
    st_d = st_q;
  end

  always_ff @(posedge clk_i) begin : p_data
    rsp_t t;
    logic [2:0] pp;
    logic [SlotW-1:0] s;
    t = '0;
    if (st_q == StIdle && req_valid_i && req_ready_o) r_q <= req_i;
    if (st_q == StSel) prod_q <= r_q.xfer_size * r_q.xfer_count;
    if (st_q == StSel && r_q.action == ActSubmit && {1'b0, ci_q} < use_n) begin
      if (fl_q[ci_q] < lim && (best_q[ChW] || bu_q[ci_q] < earl_q)) begin
        earl_q <= bu_q[ci_q];
      end
    end
    if (st_q == StDiv && (ddone || rate_i == 11'd0) && can_emit) begin
      eid_q[{best_q[1:0], PtrW'(hd_q[best_q[1:0]] + fl_q[best_q[1:0]][PtrW-1:0])}] <= nid_q;
      esz_q[{best_q[1:0], PtrW'(hd_q[best_q[1:0]] + fl_q[best_q[1:0]][PtrW-1:0])}]
        <= r_q.xfer_size;
      esb_q[{best_q[1:0], PtrW'(hd_q[best_q[1:0]] + fl_q[best_q[1:0]][PtrW-1:0])}] <= now_q;
      edn_q[{best_q[1:0], PtrW'(hd_q[best_q[1:0]] + fl_q[best_q[1:0]][PtrW-1:0])}] <= done_c;
      efl_q[{best_q[1:0], PtrW'(hd_q[best_q[1:0]] + fl_q[best_q[1:0]][PtrW-1:0])}]
        <= {1'b0, r_q.dst_is_host, r_q.src_is_host};
    end
    if (st_q == StCan) begin
      for (int p = 0; p < FifoDepth; p++) begin
        pp = 3'(p);
        s = {ci_q, PtrW'(hd_q[ci_q] + pp)};
        if ({1'b0, pp} < fl_q[ci_q] && eid_q[s] == r_q.target_id) efl_q[s][2] <= 1'b1;
      end
    end
    if (st_q == StRet && can_emit && due) begin
      t.kind = efl_q[hslot][2] ? KindCncl : KindDone;
      t.xfer_id = eid_q[hslot];
      t.chan = {2'b00, ci_q};
      t.done_cycle = edn_q[hslot];
      t.latency = lat;
      t.bytes = esz_q[hslot];
      held_q <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin : p_ctl
    rsp_t out_n;
    logic ov_n;
    logic any;
    if (!rst_ni) begin
      st_q <= StIdle;
      now_q <= '0;
      nid_q <= 32'd1;
      for (int c = 0; c < NumChannels; c++) begin
        bu_q[c] <= '0; hd_q[c] <= '0; fl_q[c] <= '0;
      end
      for (int g = 0; g < 10; g++) gc_q[g] <= (g == 6) ? '1 : '0;
      for (int k = 0; k < NumChannels*3; k++) cc_q[k] <= '0;
      ci_q <= '0; best_q <= '0; anyb_q <= 1'b0; pend_q <= 1'b0; ov_q <= 1'b0;
      out_q <= '0;
    end else begin
      out_n = out_q;
      ov_n = ov_q && !rsp_ready_i;
      any = 1'b0;
      case (st_q)
        StIdle: begin
          if (req_valid_i && req_ready_o) begin
            ci_q <= '0;
            best_q <= {1'b1, {ChW{1'b0}}};
            anyb_q <= 1'b0;
            case (req_i.action)
              ActSubmit: st_q <= StSel;
              ActTick: begin
                st_q <= StRet;
                now_q <= now_q + 64'd1;
              end
              ActCancel: st_q <= StCan;
              ActStat, ActState: st_q <= StOut;
              default: st_q <= StIdle;
            endcase
          end
        end
        StSel: begin
          if ({1'b0, ci_q} < use_n && fl_q[ci_q] < lim &&
              (best_q[ChW] || bu_q[ci_q] < earl_q)) begin
            best_q <= {1'b0, 2'b00, ci_q};
          end
          if (ci_q == 2'(NumChannels-1)) st_q <= StMul;
          ci_q <= ci_q + 2'd1;
        end
        StMul: st_q <= best_q[ChW] ? StOut : StDiv;
        StDiv: begin
          if ((ddone || rate_i == 11'd0) && can_emit) begin
            fl_q[best_q[1:0]] <= fl_q[best_q[1:0]] + 4'd1;
            bu_q[best_q[1:0]] <= done_c;
            out_n = '{kind: KindAck, ok: 1'b1, xfer_id: nid_q, chan: {2'b00, best_q[1:0]},
                      done_cycle: done_c, last: 1'b1, default: '0};
            ov_n = 1'b1;
            nid_q <= nid_q + 32'd1;
            st_q <= StIdle;
          end
        end
        StRet: begin
          // each retire is held back until the next one shows up, so the
          // final one can carry last
          if (can_emit) begin
            if (due) begin
              if (!efl_q[hslot][2]) begin
                gc_q[0] <= gc_q[0] + 64'd1;
                gc_q[1] <= gc_q[1] + {32'd0, esz_q[hslot]};
                if (efl_q[hslot][0]) gc_q[2] <= gc_q[2] + {32'd0, esz_q[hslot]};
                else if (efl_q[hslot][1]) gc_q[3] <= gc_q[3] + {32'd0, esz_q[hslot]};
                else gc_q[4] <= gc_q[4] + {32'd0, esz_q[hslot]};
                gc_q[5] <= gc_q[5] + lat;
                if (lat < gc_q[6]) gc_q[6] <= lat;
                if (lat > gc_q[7]) gc_q[7] <= lat;
                cc_q[ci_q*3+1] <= cc_q[ci_q*3+1] + 64'd1;
                cc_q[ci_q*3+2] <= cc_q[ci_q*3+2] + {32'd0, esz_q[hslot]};
              end
              hd_q[ci_q] <= hd_q[ci_q] + 3'd1;
              fl_q[ci_q] <= fl_q[ci_q] - 4'd1;
              if (pend_q) begin
                out_n = held_q;
                ov_n = 1'b1;
              end
              pend_q <= 1'b1;
            end
            if (ci_q == 2'(NumChannels-1)) st_q <= StBusy;
            ci_q <= ci_q + 2'd1;
          end
        end
        StBusy: begin
          if (can_emit) begin
            for (int c = 0; c < NumChannels; c++) begin
              if (3'(c) < use_n && bu_q[c] > now_q) begin
                any = 1'b1;
                cc_q[c*3] <= cc_q[c*3] + 64'd1;
              end
            end
            if (any) gc_q[8] <= gc_q[8] + 64'd1;
            else gc_q[9] <= gc_q[9] + 64'd1;
            st_q <= StIdle;
            if (!pend_q) begin
              out_n = '{kind: KindQuiet, last: 1'b1, default: '0};
            end else begin
              out_n = held_q;
              out_n.last = 1'b1;
            end
            pend_q <= 1'b0;
            ov_n = 1'b1;
          end
        end
        StCan: begin
          for (int p = 0; p < FifoDepth; p++) begin
            if (4'(p) < fl_q[ci_q] &&
                eid_q[{ci_q, PtrW'(hd_q[ci_q] + 3'(p))}] == r_q.target_id)
              anyb_q <= 1'b1;
          end
          if (ci_q == 2'(NumChannels-1)) st_q <= StOut;
          ci_q <= ci_q + 2'd1;
        end
        StOut: begin
          if (can_emit) begin
            out_n = '0;
            out_n.last = 1'b1;
            out_n.chan = r_q.channel_pick;
            case (r_q.action)
              ActSubmit: begin
                out_n.kind = KindAck; out_n.chan = '0;
              end
              ActCancel: begin
                out_n.kind = KindCAck; out_n.chan = '0;
                out_n.ok = anyb_q; out_n.xfer_id = r_q.target_id;
              end
              ActStat: begin
                out_n.kind = KindStat;
                if (r_q.stat_select < 4'd10) out_n.stat_value = gc_q[r_q.stat_select];
                else if (r_q.stat_select <= 4'd12 && {1'b0, r_q.channel_pick} < {2'b0, use_n})
                  out_n.stat_value =
                    cc_q[r_q.channel_pick[1:0]*3 + 32'(r_q.stat_select - 4'd10)];
              end
              default: begin
                out_n.kind = KindState;
                if ({1'b0, r_q.channel_pick} < {2'b0, use_n})
                  out_n.chan_status = {1'b0, bu_q[r_q.channel_pick[1:0]] > now_q};
                else out_n.chan_status = 2'd2;
              end
            endcase
            ov_n = 1'b1;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
      out_q <= out_n;
      ov_q <= ov_n;
    end
  end

  logic unused;
  assign unused = ^{st_d, cmatch, slot};
endmodule
`default_nettype wire

FILE: src/dma_channel_scheduler_top.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler top level
// Multichannel DMA completion scheduler with queued command front end.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: action,xfer_size,xfer_count,src/dst_is_host,target_id,
//               stat_select,channel_pick
// m_axis   out  tdata: kind..chan_status, tlast: last
// cfg      in   index 0 rate, 1 queue limit, 2 channels in use
// From request acceptance to first response: submit runs dequeue, 4-step
// channel scan, multiply, divider (skipped at rate 0). Tick visits one
// channel per cycle unless output stalls, then busy update. Cancel scans all.
// Reset is asynchronous; no clearing pass. Output stall holds the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module dma_channel_scheduler_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [111:0] s_axis_tdata,  // action,size,count,src,dst,target,stat,pick
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [271:0] m_axis_tdata,  // kind,ok,id,chan,done,lat,bytes,stat,status
  output logic         m_axis_tlast,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [1:0]   cfg_index_i,
  input  wire  [10:0]  cfg_data_i
);
  import dcs_pkg::*;
  req_t  inreq, qreq;
  rsp_t  rsp;
  logic  qv, qr, idle;
  logic [10:0] rate_q;
  logic [3:0]  lim_q;
  logic [2:0]  ch_q;

  assign inreq.action       = s_axis_tdata[2:0];
  assign inreq.xfer_size    = s_axis_tdata[34:3];
  assign inreq.xfer_count   = s_axis_tdata[66:35];
  assign inreq.src_is_host  = s_axis_tdata[67];
  assign inreq.dst_is_host  = s_axis_tdata[68];
  assign inreq.target_id    = s_axis_tdata[100:69];
  assign inreq.stat_select  = s_axis_tdata[104:101];
  assign inreq.channel_pick = s_axis_tdata[108:105];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 11'd16; lim_q <= 4'd0; ch_q <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegRate:  rate_q <= cfg_data_i;
        RegLimit: lim_q <= cfg_data_i[3:0];
        RegChans: ch_q <= cfg_data_i[2:0];
        default:  rate_q <= rate_q;
      endcase
    end
  end

  dcs_req_fifo u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(inreq), .out_valid_o(qv), .out_ready_i(qr), .out_req_o(qreq)
  );

  dcs_engine u_eng (
    .clk_i, .rst_ni, .req_valid_i(qv), .req_ready_o(qr), .req_i(qreq),
    .rate_i(rate_q), .limit_i(lim_q), .chans_i(ch_q),
    .rsp_valid_o(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_o(rsp), .idle_o(idle)
  );

  assign m_axis_tdata = {6'd0, rsp.chan_status, rsp.stat_value, rsp.bytes, rsp.latency,
                         rsp.done_cycle, rsp.chan, rsp.xfer_id, rsp.ok, rsp.kind};
  assign m_axis_tlast = rsp.last;

  logic unused;
  assign unused = ^{s_axis_tdata[111:109], idle};
endmodule
`default_nettype wire

FILE: src/dcs_checker.sv
// ----------------------------------------------------------------------------
// DMA channel scheduler port checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dma_channel_scheduler_top_defines.svh"
module dcs_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [271:0] m_axis_tdata,
  input wire         m_axis_tlast
);
  import dcs_pkg::*;
  logic       stall;
  logic [2:0] kind;

  assign stall = m_axis_tvalid && !m_axis_tready;
  assign kind  = m_axis_tdata[2:0];

  `DCS_ASSERT_NXT(a_hold, clk_i, rst_ni, stall, $stable(m_axis_tdata), "stalled result changed")
  `DCS_ASSERT_NXT(a_vhold, clk_i, rst_ni, stall, m_axis_tvalid, "stalled result dropped")
  `DCS_ASSERT_IMP(a_kind, clk_i, rst_ni, m_axis_tvalid, kind <= KindState, "bad kind")
  `DCS_ASSERT_IMP(a_last, clk_i, rst_ni, m_axis_tvalid && kind >= KindQuiet, m_axis_tlast, "not last")
endmodule
bind dma_channel_scheduler_top dcs_checker u_chk (.*);
`default_nettype wire
